// File: hw/rtl/iass_pkg.sv
// Shared types and constants for the I2C ADC init and scan sequencer.
// No dependencies; every other file of the block imports this package.
package iass_pkg;

   localparam int CHANNEL_COUNT = 8;
   localparam int SAMPLE_WIDTH  = 12;
   localparam int SAMPLE_SHIFT  = 16 - SAMPLE_WIDTH;
   localparam int CH_W          = 4;   // channel index that can also hold CHANNEL_COUNT

   // event kinds
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;
   localparam logic [1:0] KIND_FAIL  = 2'd3;

   // register file indexes
   localparam logic [1:0] CSR_MASK     = 2'd0;
   localparam logic [1:0] CSR_TEMP_EN  = 2'd1;
   localparam logic [1:0] CSR_EXT_REF  = 2'd2;
   localparam logic [1:0] CSR_DEV_ADDR = 2'd3;

   // status codes
   localparam logic [2:0] ST_NONE        = 3'd0;
   localparam logic [2:0] ST_BAD_MAKER   = 3'd1;
   localparam logic [2:0] ST_BAD_REV     = 3'd2;
   localparam logic [2:0] ST_INIT_FAIL   = 3'd3;
   localparam logic [2:0] ST_READ_FAIL   = 3'd4;
   localparam logic [2:0] ST_OVERRUN     = 3'd5;
   localparam logic [2:0] ST_SCAN_DONE   = 3'd6;
   localparam logic [2:0] ST_INITIALIZED = 3'd7;

   // converter register map
   localparam logic [7:0] REG_MAKER     = 8'h3E;
   localparam logic [7:0] REG_REVISION  = 8'h3F;
   localparam logic [7:0] REG_BUSY      = 8'h0C;
   localparam logic [7:0] REG_ADVANCED  = 8'h0B;
   localparam logic [7:0] REG_RATE      = 8'h07;
   localparam logic [7:0] REG_DISABLE   = 8'h08;
   localparam logic [7:0] REG_INT_MASK  = 8'h03;
   localparam logic [7:0] REG_CONFIG    = 8'h00;
   localparam logic [7:0] REG_DATA_BASE = 8'h20;

   localparam logic [7:0] MAKER_ID     = 8'd1;
   localparam logic [7:0] REVISION_ID  = 8'd9;
   localparam logic [7:0] BUSY_BIT     = 8'b0000_0010;
   localparam logic [7:0] INT_MASK_ALL = 8'hFF;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_high;
      logic [7:0] rx_low;
   } req_type;

   typedef struct packed {
      logic        request_valid;
      logic [6:0]  bus_address;
      logic [7:0]  register_address;
      logic [7:0]  write_value;
      logic [1:0]  send_count;
      logic [1:0]  receive_count;
      logic        sample_valid;
      logic [2:0]  sample_channel;
      logic [11:0] sample_value;
      logic [2:0]  status;
   } rsp_type;

   // result of one channel search
   typedef struct packed {
      logic            done;
      logic            found;
      logic [CH_W-1:0] chan;
   } fnd_type;

endpackage

// File: hw/rtl/i2c_adc_init_and_scan_sequencer_core.sv
// Sequencer for an eight-channel I2C converter: init chain and channel scans.
// Depends on iass_pkg and iass_chan_finder.
//
// Usage: events (start, poll tick, transfer done, transfer failed) arrive as
// beats on the req_ channel; each event yields exactly one rsp_ beat holding
// an optional bus transaction request, an optional channel sample and a
// status code. The user must write the csr_ port registers (channel mask,
// temperature enable, external reference, device address) only while the
// block is idle; the block itself does not enforce it. Most events give their
// result beat in the cycle after acceptance. An event that must pick the next
// monitored channel runs the channel search unit, which tests one channel per
// cycle, before its result beat is registered.
// Flow control: one event at a time; req_stall is high from acceptance until
// the result beat is taken, so no new event is taken before that beat.
// A stalled result beat holds its value and keeps the input stalled.
// Reset (synchronous, active high) returns to the idle phase with no scan
// running and the registers at their defaults; no clearing pass is needed.
module i2c_adc_init_and_scan_sequencer_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  iass_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output iass_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);
   import iass_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_OUT
   } state_type;

   typedef enum logic [3:0] {
      PH_IDLE, PH_MAKER, PH_REVISION, PH_BUSY, PH_ADVANCED, PH_RATE,
      PH_DISABLE, PH_INT_MASK, PH_CONFIG, PH_RUNNING, PH_FAILED
   } phase_type;

   state_type       state_ff, state_in;
   phase_type       phase_ff, phase_in;
   logic [CH_W-1:0] scan_ch_ff, scan_ch_in;
   logic            scan_busy_ff, scan_busy_in;
   logic            init_done_ff, init_done_in;
   rsp_type         res_ff, res_in;

   logic [7:0] mask_ff, mask_in;
   logic       temp_en_ff, temp_en_in;
   logic       ext_ref_ff, ext_ref_in;
   logic [6:0] dev_addr_ff, dev_addr_in;

   logic            fnd_start;
   logic [CH_W-1:0] fnd_from;
   fnd_type         fnd;
   logic            accept;
   logic [15:0]     raw;

   function automatic rsp_type put_request(input rsp_type r, input logic [6:0] dev,
                                           input logic [7:0] reg_addr,
                                           input logic [7:0] val,
                                           input logic [1:0] nsend,
                                           input logic [1:0] nrecv);
      rsp_type o;
      o                  = r;
      o.request_valid    = 1'b1;
      o.bus_address      = dev;
      o.register_address = reg_addr;
      o.write_value      = val;
      o.send_count       = nsend;
      o.receive_count    = nrecv;
      return o;
   endfunction

   iass_chan_finder u_finder (
      .clock  (clock),
      .reset  (reset),
      .start  (fnd_start),
      .from   (fnd_from),
      .mask   (mask_ff),
      .result (fnd)
   );

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = res_ff;
   assign raw       = {req_data.rx_high, req_data.rx_low};

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      scan_ch_in   = scan_ch_ff;
      scan_busy_in = scan_busy_ff;
      init_done_in = init_done_ff;
      res_in       = res_ff;
      mask_in      = mask_ff;
      temp_en_in   = temp_en_ff;
      ext_ref_in   = ext_ref_ff;
      dev_addr_in  = dev_addr_ff;
      fnd_start    = 1'b0;
      fnd_from     = '0;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MASK:     mask_in     = csr_wdata;
            CSR_TEMP_EN:  temp_en_in  = csr_wdata[0];
            CSR_EXT_REF:  ext_ref_in  = csr_wdata[0];
            CSR_DEV_ADDR: dev_addr_in = csr_wdata[6:0];
            default:      ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in   = '0;
               state_in = S_OUT;
               unique case (req_data.kind)
                  KIND_START: begin
                     if (phase_ff == PH_IDLE || phase_ff == PH_FAILED) begin
                        init_done_in = 1'b0;
                        scan_busy_in = 1'b0;
                        scan_ch_in   = '0;
                        phase_in     = PH_MAKER;
                        res_in = put_request('0, dev_addr_ff, REG_MAKER, 8'd0, 2'd1, 2'd1);
                     end
                  end
                  KIND_TICK: begin
                     if (phase_ff == PH_RUNNING) begin
                        if (scan_busy_ff) begin
                           res_in.status = ST_OVERRUN;
                        end else begin
                           scan_busy_in = 1'b1;
                           fnd_start    = 1'b1;
                           fnd_from     = '0;
                           state_in     = S_SEARCH;
                        end
                     end
                  end
                  KIND_DONE: begin
                     unique case (phase_ff)
                        PH_MAKER: begin
                           if (req_data.rx_high != MAKER_ID) begin
                              res_in.status = ST_BAD_MAKER;
                              phase_in      = PH_FAILED;
                           end else begin
                              phase_in = PH_REVISION;
                              res_in = put_request('0, dev_addr_ff, REG_REVISION, 8'd0,
                                                   2'd1, 2'd1);
                           end
                        end
                        PH_REVISION: begin
                           if (req_data.rx_high != REVISION_ID) begin
                              res_in.status = ST_BAD_REV;
                              phase_in      = PH_FAILED;
                           end else begin
                              phase_in = PH_BUSY;
                              res_in = put_request('0, dev_addr_ff, REG_BUSY, 8'd0,
                                                   2'd1, 2'd1);
                           end
                        end
                        PH_BUSY: begin
                           if ((req_data.rx_high & BUSY_BIT) != 8'd0) begin
                              // still busy: poll again
                              res_in = put_request('0, dev_addr_ff, REG_BUSY, 8'd0,
                                                   2'd1, 2'd1);
                           end else begin
                              phase_in = PH_ADVANCED;
                              res_in = put_request('0, dev_addr_ff, REG_ADVANCED,
                                                   {6'd0, !temp_en_ff, ext_ref_ff},
                                                   2'd2, 2'd0);
                           end
                        end
                        PH_ADVANCED: begin
                           phase_in = PH_RATE;
                           res_in = put_request('0, dev_addr_ff, REG_RATE, 8'd1, 2'd2, 2'd0);
                        end
                        PH_RATE: begin
                           phase_in = PH_DISABLE;
                           res_in = put_request('0, dev_addr_ff, REG_DISABLE, ~mask_ff,
                                                2'd2, 2'd0);
                        end
                        PH_DISABLE: begin
                           phase_in = PH_INT_MASK;
                           res_in = put_request('0, dev_addr_ff, REG_INT_MASK, INT_MASK_ALL,
                                                2'd2, 2'd0);
                        end
                        PH_INT_MASK: begin
                           phase_in = PH_CONFIG;
                           res_in = put_request('0, dev_addr_ff, REG_CONFIG, 8'd1,
                                                2'd2, 2'd0);
                        end
                        PH_CONFIG: begin
                           phase_in = PH_RUNNING;
                        end
                        PH_RUNNING: begin
                           if (scan_busy_ff) begin
                              res_in.sample_valid   = 1'b1;
                              res_in.sample_channel = scan_ch_ff[2:0];
                              res_in.sample_value   = 12'(raw >> SAMPLE_SHIFT);
                              fnd_start = 1'b1;
                              fnd_from  = scan_ch_ff + 1'b1;
                              state_in  = S_SEARCH;
                           end
                        end
                        default: ;
                     endcase
                  end
                  KIND_FAIL: begin
                     if (phase_ff >= PH_MAKER && phase_ff <= PH_CONFIG) begin
                        res_in.status = ST_INIT_FAIL;
                        phase_in      = PH_FAILED;
                     end else if (phase_ff == PH_RUNNING && scan_busy_ff) begin
                        scan_busy_in = 1'b0;
                        if (!init_done_ff) begin
                           res_in.status = ST_INIT_FAIL;
                           phase_in      = PH_FAILED;
                        end else begin
                           res_in.status = ST_READ_FAIL;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SEARCH: begin
            if (fnd.done) begin
               scan_ch_in = fnd.chan;
               state_in   = S_OUT;
               if (fnd.found) begin
                  res_in = put_request(res_ff, dev_addr_ff,
                                       REG_DATA_BASE + 8'(fnd.chan), 8'd0, 2'd1, 2'd2);
               end else begin
                  // no channel left: end the scan
                  scan_busy_in = 1'b0;
                  if (!init_done_ff) begin
                     init_done_in  = 1'b1;
                     res_in.status = ST_INITIALIZED;
                  end else begin
                     res_in.status = ST_SCAN_DONE;
                  end
               end
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         scan_ch_ff   <= '0;
         scan_busy_ff <= 1'b0;
         init_done_ff <= 1'b0;
         mask_ff      <= 8'hFF;
         temp_en_ff   <= 1'b0;
         ext_ref_ff   <= 1'b0;
         dev_addr_ff  <= 7'd29;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         scan_ch_ff   <= scan_ch_in;
         scan_busy_ff <= scan_busy_in;
         init_done_ff <= init_done_in;
         mask_ff      <= mask_in;
         temp_en_ff   <= temp_en_in;
         ext_ref_ff   <= ext_ref_in;
         dev_addr_ff  <= dev_addr_in;
      end
      res_ff <= res_in;
   end

endmodule

// File: hw/rtl/iass_chan_finder.sv
// Channel search unit: steps one channel per cycle from a start index
// to the next monitored channel. Depends on iass_pkg.
module iass_chan_finder (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [iass_pkg::CH_W-1:0] from,
   input  logic [7:0]               mask,
   output iass_pkg::fnd_type        result
);
   import iass_pkg::*;

   logic            busy_ff, busy_in;
   logic [CH_W-1:0] cur_ff, cur_in;
   logic            past_end;
   logic            hit;

   assign past_end = (cur_ff >= CH_W'(CHANNEL_COUNT));
   assign hit      = !past_end && mask[cur_ff[2:0]];

   always_comb begin
      busy_in = busy_ff;
      cur_in  = cur_ff;
      result  = '0;
      if (start) begin
         busy_in = 1'b1;
         cur_in  = from;
      end else if (busy_ff) begin
         if (past_end || hit) begin
            busy_in      = 1'b0;
            result.done  = 1'b1;
            result.found = hit;
            result.chan  = past_end ? CH_W'(CHANNEL_COUNT) : cur_ff;
         end else begin
            cur_in = cur_ff + 1'b1;   // advance to the next channel
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cur_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cur_ff  <= cur_in;
      end
   end

endmodule

// File: hw/rtl/iass_checker.sv
// Port-level checks for the sequencer core, attached by bind.
// Depends on iass_pkg and i2c_adc_init_and_scan_sequencer_core.
module iass_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input iass_pkg::rsp_type rsp_data
);
   import iass_pkg::*;

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // one event in flight: stall right after acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while an event is in flight");

   // no result beat while the input side is open
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result beat waits");

   a_request_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.request_valid |->
         rsp_data.bus_address == 7'd0 && rsp_data.register_address == 8'd0 &&
         rsp_data.write_value == 8'd0 && rsp_data.send_count == 2'd0 &&
         rsp_data.receive_count == 2'd0)
      else $error("request fields set without a request");

   a_sample_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.sample_valid |->
         rsp_data.sample_channel == 3'd0 && rsp_data.sample_value == 12'd0)
      else $error("sample fields set without a sample");

endmodule

bind i2c_adc_init_and_scan_sequencer_core iass_checker u_iass_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: bench/i2c_adc_init_and_scan_sequencer_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the I2C ADC init and scan sequencer core.
// Depends on iass_pkg and the core; plays the bus engine and timer side and
// checks every result beat against a cycle-free model of the sequencer.
module i2c_adc_init_and_scan_sequencer_core_test;
   import iass_pkg::*;

   localparam int CYCLE_LIMIT     = 300000;
   localparam int DRAIN_CYCLES    = 14;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 300;
   localparam int LONG_HOLD       = 60;
   localparam int HOLD_SPACING    = 600;

   typedef enum logic [3:0] {
      PH_IDLE, PH_MAKER, PH_REVISION, PH_BUSY, PH_ADVANCED, PH_RATE,
      PH_DISABLE, PH_INT_MASK, PH_CONFIG, PH_RUNNING, PH_FAILED
   } seq_phase_e;

   typedef struct {
      seq_phase_e ph;
      logic [3:0] scan_chan;
      logic       scan_busy;
      logic       init_done;
      logic [7:0] mask;
      logic       temp_en;
      logic       ext_ref;
      logic [6:0] dev_addr;
   } seq_state_t;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic       csr_write_en = 1'b0;
   logic [1:0] csr_index = CSR_MASK;
   logic [7:0] csr_wdata = 8'h00;

   seq_state_t plan_state;    // advanced as events are queued
   seq_state_t mirror_state;  // advanced as events are accepted
   req_type    event_queue[$];
   rsp_type    pending_outputs[$];
   logic       bus_open = 1'b0;
   logic [7:0] open_reg = 8'h00;
   logic       quiet = 1'b0;
   logic       req_took = 1'b0;
   int         gap_left = 0;
   int         stall_left = 0;
   int         hold_left = 0;
   int         next_hold_at = 200;
   int         beats_taken = 0;
   int         fail_count = 0;
   int         cycle_count = 0;
   int         counted;
   logic [7:0] phase_mask [PHASES];
   logic [6:0] phase_addr [PHASES];

   i2c_adc_init_and_scan_sequencer_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic void bus_request(inout rsp_type r, input logic [6:0] addr,
                                       input logic [7:0] reg_addr, value,
                                       input logic [1:0] n_send, n_recv);
      r.request_valid    = 1'b1;
      r.bus_address      = addr;
      r.register_address = reg_addr;
      r.write_value      = value;
      r.send_count       = n_send;
      r.receive_count    = n_recv;
   endfunction

   // Read the next monitored channel at or above 'from', or close the scan.
   function automatic void scan_next(inout seq_state_t s, inout rsp_type r, input int from);
      int c;
      c = from;
      while (c < CHANNEL_COUNT && !s.mask[c]) c++;
      s.scan_chan = c[3:0];
      if (c < CHANNEL_COUNT) begin
         bus_request(r, s.dev_addr, REG_DATA_BASE + 8'(c), 8'h00, 2'd1, 2'd2);
      end else begin
         s.scan_busy = 1'b0;
         if (!s.init_done) begin
            s.init_done = 1'b1;
            r.status = ST_INITIALIZED;
         end else begin
            r.status = ST_SCAN_DONE;
         end
      end
   endfunction

   function automatic void advance_sequencer(inout seq_state_t s, input req_type ev,
                                             output rsp_type r);
      logic [15:0] raw;
      r = '0;
      case (ev.kind)
         KIND_START: begin
            if (s.ph == PH_IDLE || s.ph == PH_FAILED) begin
               s.init_done = 1'b0;
               s.scan_busy = 1'b0;
               s.scan_chan = '0;
               s.ph = PH_MAKER;
               bus_request(r, s.dev_addr, REG_MAKER, 8'h00, 2'd1, 2'd1);
            end
         end
         KIND_TICK: begin
            if (s.ph == PH_RUNNING) begin
               if (s.scan_busy) begin
                  r.status = ST_OVERRUN;
               end else begin
                  s.scan_busy = 1'b1;
                  scan_next(s, r, 0);
               end
            end
         end
         KIND_DONE: begin
            case (s.ph)
               PH_MAKER: begin
                  if (ev.rx_high != MAKER_ID) begin
                     r.status = ST_BAD_MAKER;
                     s.ph = PH_FAILED;
                  end else begin
                     s.ph = PH_REVISION;
                     bus_request(r, s.dev_addr, REG_REVISION, 8'h00, 2'd1, 2'd1);
                  end
               end
               PH_REVISION: begin
                  if (ev.rx_high != REVISION_ID) begin
                     r.status = ST_BAD_REV;
                     s.ph = PH_FAILED;
                  end else begin
                     s.ph = PH_BUSY;
                     bus_request(r, s.dev_addr, REG_BUSY, 8'h00, 2'd1, 2'd1);
                  end
               end
               PH_BUSY: begin
                  if ((ev.rx_high & BUSY_BIT) != 8'h00) begin
                     bus_request(r, s.dev_addr, REG_BUSY, 8'h00, 2'd1, 2'd1);
                  end else begin
                     s.ph = PH_ADVANCED;
                     bus_request(r, s.dev_addr, REG_ADVANCED,
                                 {6'b0, ~s.temp_en, s.ext_ref}, 2'd2, 2'd0);
                  end
               end
               PH_ADVANCED: begin
                  s.ph = PH_RATE;
                  bus_request(r, s.dev_addr, REG_RATE, 8'h01, 2'd2, 2'd0);
               end
               PH_RATE: begin
                  s.ph = PH_DISABLE;
                  bus_request(r, s.dev_addr, REG_DISABLE, ~s.mask, 2'd2, 2'd0);
               end
               PH_DISABLE: begin
                  s.ph = PH_INT_MASK;
                  bus_request(r, s.dev_addr, REG_INT_MASK, INT_MASK_ALL, 2'd2, 2'd0);
               end
               PH_INT_MASK: begin
                  s.ph = PH_CONFIG;
                  bus_request(r, s.dev_addr, REG_CONFIG, 8'h01, 2'd2, 2'd0);
               end
               PH_CONFIG: s.ph = PH_RUNNING;
               PH_RUNNING: begin
                  if (s.scan_busy) begin
                     raw = {ev.rx_high, ev.rx_low};
                     r.sample_valid   = 1'b1;
                     r.sample_channel = s.scan_chan[2:0];
                     r.sample_value   = 12'(raw >> SAMPLE_SHIFT);
                     scan_next(s, r, int'(s.scan_chan) + 1);
                  end
               end
               default: ;
            endcase
         end
         default: begin
            if (s.ph >= PH_MAKER && s.ph <= PH_CONFIG) begin
               r.status = ST_INIT_FAIL;
               s.ph = PH_FAILED;
            end else if (s.ph == PH_RUNNING && s.scan_busy) begin
               s.scan_busy = 1'b0;
               if (!s.init_done) begin
                  r.status = ST_INIT_FAIL;
                  s.ph = PH_FAILED;
               end else begin
                  r.status = ST_READ_FAIL;
               end
            end
         end
      endcase
   endfunction

   // Queue one event and track which bus transfer it leaves open.
   function automatic bit enqueue_event(input req_type ev);
      rsp_type r;
      advance_sequencer(plan_state, ev, r);
      if (r.request_valid) begin
         bus_open = 1'b1;
         open_reg = r.register_address;
      end else if (ev.kind == KIND_DONE || ev.kind == KIND_FAIL) begin
         bus_open = 1'b0;
      end
      event_queue.push_back(ev);
      return r != '0;
   endfunction

   function automatic logic [7:0] rand_byte();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   // Mostly behave like a working bus engine and timer; now and then misbehave.
   function automatic req_type pick_event();
      req_type ev;
      int      roll;
      roll = $urandom_range(99);
      ev.kind    = KIND_START;
      ev.rx_high = rand_byte();
      ev.rx_low  = rand_byte();
      if (roll < 6) begin
         ev.kind = 2'($urandom_range(3));
      end else if (bus_open) begin
         if (roll < 10) begin
            ev.kind = KIND_TICK;
         end else if (roll < 12) begin
            ev.kind = KIND_START;
         end else if (roll < (plan_state.init_done ? 16 : 20)) begin
            ev.kind = KIND_FAIL;
         end else begin
            ev.kind = KIND_DONE;
            if (open_reg == REG_MAKER && $urandom_range(99) < 85) begin
               ev.rx_high = MAKER_ID;
            end else if (open_reg == REG_REVISION && $urandom_range(99) < 85) begin
               ev.rx_high = REVISION_ID;
            end else if (open_reg == REG_BUSY) begin
               if ($urandom_range(99) < 35) ev.rx_high = ev.rx_high | BUSY_BIT;
               else ev.rx_high = ev.rx_high & ~BUSY_BIT;
            end
         end
      end else if (plan_state.ph == PH_IDLE || plan_state.ph == PH_FAILED) begin
         ev.kind = (roll < 15) ? 2'($urandom_range(3)) : KIND_START;
      end else begin
         ev.kind = (roll < 15) ? 2'($urandom_range(3)) : KIND_TICK;
      end
      return ev;
   endfunction

   task automatic post(input logic [1:0] kind, input logic [7:0] hi);
      void'(enqueue_event({kind, hi, rand_byte()}));
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
   endtask

   task automatic configure(input logic [7:0] mask, input logic temp_en, ext_ref,
                            input logic [6:0] addr);
      csr_write(CSR_MASK, mask);
      csr_write(CSR_TEMP_EN, {7'b0, temp_en});
      csr_write(CSR_EXT_REF, {7'b0, ext_ref});
      csr_write(CSR_DEV_ADDR, {1'b0, addr});
      @(negedge clock);
      csr_write_en <= 1'b0;
      mirror_state.mask     = mask;
      mirror_state.temp_en  = temp_en;
      mirror_state.ext_ref  = ext_ref;
      mirror_state.dev_addr = addr;
      plan_state.mask       = mask;
      plan_state.temp_en    = temp_en;
      plan_state.ext_ref    = ext_ref;
      plan_state.dev_addr   = addr;
   endtask

   task automatic wait_drain();
      while (event_queue.size() != 0 || req_valid || pending_outputs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input int unsigned want, got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Event driver: hold a beat until taken, then advance or idle a while.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_took)) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (event_queue.size() != 0) begin
            req_data  <= event_queue.pop_front();
            req_valid <= 1'b1;
            if (!quiet && $urandom_range(99) < 15) gap_left = $urandom_range(1, 5);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure, with an occasional long hold to fill the block.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!quiet && beats_taken >= next_hold_at) begin
         hold_left = LONG_HOLD - 1;
         next_hold_at += HOLD_SPACING;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (!quiet && $urandom_range(99) < 12) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      req_took = !reset && req_valid && !req_stall;
      if (req_took) begin
         advance_sequencer(mirror_state, req_data, want);
         pending_outputs.push_back(want);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_taken++;
         if (pending_outputs.size() == 0) begin
            $error("result beat with no event outstanding");
            fail_count++;
         end else begin
            want = pending_outputs.pop_front();
            check_field("request_valid", want.request_valid, rsp_data.request_valid);
            check_field("bus_address", want.bus_address, rsp_data.bus_address);
            check_field("register_address", want.register_address,
                        rsp_data.register_address);
            check_field("write_value", want.write_value, rsp_data.write_value);
            check_field("send_count", want.send_count, rsp_data.send_count);
            check_field("receive_count", want.receive_count, rsp_data.receive_count);
            check_field("sample_valid", want.sample_valid, rsp_data.sample_valid);
            check_field("sample_channel", want.sample_channel, rsp_data.sample_channel);
            check_field("sample_value", want.sample_value, rsp_data.sample_value);
            check_field("status", want.status, rsp_data.status);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      plan_state.ph        = PH_IDLE;
      plan_state.scan_chan = '0;
      plan_state.scan_busy = 1'b0;
      plan_state.init_done = 1'b0;
      plan_state.mask      = 8'hFF;
      plan_state.temp_en   = 1'b0;
      plan_state.ext_ref   = 1'b0;
      plan_state.dev_addr  = 7'd29;
      mirror_state = plan_state;
      phase_mask = '{8'hFF, 8'h01, 8'h80, 8'($urandom_range(1, 255)), 8'hA5,
                     8'($urandom_range(1, 255))};
      phase_addr = '{7'd127, 7'd0, 7'($urandom_range(127)), 7'd29,
                     7'($urandom_range(127)), 7'd127};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // stray events before any start, then a wrong maker ID
      configure(8'hFF, 1'b0, 1'b0, 7'd127);
      post(KIND_TICK, 8'h00);
      post(KIND_FAIL, 8'hFF);
      post(KIND_START, 8'h00);
      post(KIND_DONE, 8'hFE);
      wait_drain();

      // start ignored mid-chain, then a wrong revision
      configure(8'h01, 1'b1, 1'b1, 7'd0);
      post(KIND_START, 8'h00);
      post(KIND_START, 8'h00);
      post(KIND_DONE, MAKER_ID);
      post(KIND_DONE, 8'h08);
      wait_drain();

      // busy re-read, then a bus failure partway through the register writes
      configure(8'h01, 1'b1, 1'b0, 7'd29);
      post(KIND_START, 8'h00);
      post(KIND_DONE, MAKER_ID);
      post(KIND_DONE, REVISION_ID);
      post(KIND_DONE, 8'hFF);
      post(KIND_DONE, 8'hFD);
      post(KIND_DONE, 8'h00);
      post(KIND_FAIL, 8'h00);
      wait_drain();

      // full init chain, overrun tick, then a failed read in the first scan
      configure(8'h80, 1'b0, 1'b1, 7'd42);
      post(KIND_START, 8'h00);
      post(KIND_DONE, MAKER_ID);
      post(KIND_DONE, REVISION_ID);
      post(KIND_DONE, 8'h00);
      repeat (5) post(KIND_DONE, rand_byte());
      post(KIND_TICK, 8'h00);
      post(KIND_TICK, 8'h00);
      post(KIND_FAIL, 8'h00);

      for (int p = 0; p < PHASES; p++) begin
         wait_drain();
         if (p == PHASES - 1) quiet = 1'b1;
         configure(phase_mask[p], p[0], p[1], phase_addr[p]);
         counted = 0;
         while (counted < ITEMS_PER_PHASE)
            if (enqueue_event(pick_event())) counted++;
      end
      wait_drain();

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
